FILE: src/hsc_pkg.sv
// hsc_pkg: shared types, pattern constants and helper functions of the classifier
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

  localparam int unsigned WinLen     = 14;
  localparam int unsigned NumCells   = WinLen - 1;
  localparam int unsigned NumClasses = 12;
  localparam int unsigned NumPat     = 18;

  localparam logic [3:0] CODE_NONE = 4'd12;

  typedef logic [7:0]             byte_t;
  typedef logic [0:WinLen-1][7:0] win_t;
  typedef logic [NumClasses-1:0]  hits_t;
  typedef logic [3:0]             code_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // patterns aligned to the window tail, zero bytes are wildcards
  localparam win_t PAT_TXT [NumPat] = '{
    112'h00_00_00_00_00_00_00_79_6f_75_74_75_62_65,
    112'h00_00_00_67_6f_6f_67_6c_65_76_69_64_65_6f,
    112'h00_00_00_00_00_00_00_6e_65_74_66_6c_69_78,
    112'h00_00_00_00_00_00_66_61_63_65_62_6f_6f_6b,
    112'h00_00_00_00_00_00_00_00_00_66_62_63_64_6e,
    112'h00_00_00_00_00_69_6e_73_74_61_67_72_61_6d,
    112'h00_00_00_00_00_00_00_00_74_69_6b_74_6f_6b,
    112'h00_00_00_00_00_6d_75_73_69_63_61_6c_6c_79,
    112'h00_00_00_00_00_00_00_74_77_69_74_74_65_72,
    112'h00_00_00_00_00_00_00_00_00_74_77_69_6d_67,
    112'h00_00_00_00_00_00_77_68_61_74_73_61_70_70,
    112'h00_00_00_00_00_00_74_65_6c_65_67_72_61_6d,
    112'h00_00_00_00_00_00_00_00_67_69_74_68_75_62,
    112'h00_00_00_00_00_00_00_00_72_65_64_64_69_74,
    112'h00_00_73_74_65_61_6d_70_6f_77_65_72_65_64,
    112'h73_74_65_61_6d_63_6f_6d_6d_75_6e_69_74_79,
    112'h00_00_00_00_00_00_00_00_67_6f_6f_67_6c_65,
    112'h00_00_00_00_00_00_00_67_73_74_61_74_69_63
  };

  localparam code_t PAT_CLS [NumPat] = '{
    4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5,
    4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11
  };

  function automatic byte_t fold_byte(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic code_t pick_code(input hits_t h);
    code_t r;
    r = CODE_NONE;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (h[c]) begin
        r = code_t'(c);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/hostname_substring_classifier_core.sv
// hostname_substring_classifier_core: byte-serial server name classifier top level
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o   byte_value_i, byte_present_i, last_byte_i
//   out      out  out_valid_o/out_stall_i class_code_o
//
// a byte per cycle unless stalled; window shift and all compares end in the transfer cycle
// the result of a last byte shows on the output in the cycle after its transfer
// reset clears the window cells, the class flags and the output valid
// input stalls only while a result waits and the output is stalled
`timescale 1ns / 1ps
`default_nettype none

module hostname_substring_classifier_core
  import hsc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  byte_value_i,
  input  wire         byte_present_i,
  input  wire         last_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [3:0]  class_code_o
);

  logic       in_xfer;
  cell_ctrl_t cell_ctrl;
  win_t       win;
  hits_t      new_hits;
  hits_t      hits_all;
  hits_t      hits_d, hits_q;
  logic       out_valid_d, out_valid_q;
  code_t      code_d, code_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  assign cell_ctrl.shift = in_xfer & byte_present_i;
  assign cell_ctrl.clear = in_xfer & last_byte_i;

  assign win[WinLen-1] = fold_byte(byte_value_i);

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    hsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .d_i    (win[k+1]),
      .q_o    (win[k])
    );
  end

  hsc_match u_match (
    .win_i  (win),
    .hits_o (new_hits)
  );

  assign hits_all = byte_present_i ? (hits_q | new_hits) : hits_q;

  always_comb begin
    hits_d      = hits_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer) begin
      if (last_byte_i) begin
        hits_d      = '0;
        out_valid_d = 1'b1;
        code_d      = pick_code(hits_all);
      end else begin
        hits_d = hits_all;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_valid_o  = out_valid_q;
  assign class_code_o = code_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> out_valid_o && class_code_o <= CODE_NONE)
    else $error("last byte transfer did not produce a valid code");

  a_last_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> hits_q == '0 && win[0] == 8'h00 && win[NumCells-1] == 8'h00)
    else $error("flags or window not cleared after name end");

  a_empty_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !byte_present_i && !last_byte_i |=> $stable(hits_q) && $stable(win[0]))
    else $error("state changed on an item without a byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !in_xfer)
    else $error("transfer accepted while a stalled result waits");

endmodule

`default_nettype wire

FILE: src/hsc_cell.sv
// hsc_cell: one byte slot of the shifting character window
`timescale 1ns / 1ps
`default_nettype none

module hsc_cell
  import hsc_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire byte_t      d_i,
  output byte_t           q_o
);

  byte_t char_d, char_q;

  always_comb begin
    char_d = char_q;
    if (ctrl_i.clear) begin
      char_d = '0;
    end else if (ctrl_i.shift) begin
      char_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign q_o = char_q;

endmodule

`default_nettype wire

FILE: src/hsc_match.sv
// hsc_match: compares the window tail against all patterns and returns class hits
`timescale 1ns / 1ps
`default_nettype none

module hsc_match
  import hsc_pkg::*;
(
  input  wire win_t win_i,
  output hits_t     hits_o
);

  logic [NumPat-1:0] pat_hit;

  always_comb begin
    for (int p = 0; p < NumPat; p++) begin
      pat_hit[p] = 1'b1;
      for (int i = 0; i < WinLen; i++) begin
        if (PAT_TXT[p][i] != 8'h00 && PAT_TXT[p][i] != win_i[i]) begin
          pat_hit[p] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hits_o = '0;
    for (int p = 0; p < NumPat; p++) begin
      if (pat_hit[p]) begin
        hits_o[PAT_CLS[p]] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for the byte-serial server name classifier core
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_PATTERNS = 18;
  localparam int NUM_CLASSES  = 12;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [3:0] {
    CLS_VIDEO     = 4'd0,
    CLS_MOVIES    = 4'd1,
    CLS_SOCIAL    = 4'd2,
    CLS_PHOTO     = 4'd3,
    CLS_SHORTS    = 4'd4,
    CLS_MICROBLOG = 4'd5,
    CLS_CHAT      = 4'd6,
    CLS_MESSENGER = 4'd7,
    CLS_CODE_HOST = 4'd8,
    CLS_FORUM     = 4'd9,
    CLS_GAMES     = 4'd10,
    CLS_SEARCH    = 4'd11,
    CLS_NONE      = 4'd12
  } class_code_e;

  typedef struct packed {
    logic [7:0] value;
    logic       present;
    logic       last;
  } name_item_t;

  typedef struct packed {
    logic [7:0]  value;
    logic        present;
    logic        last;
    logic        typed;
    class_code_e code;
  } stim_row_t;

  // lowercase patterns, first character in the highest used byte
  localparam logic [111:0] PATTERN_TEXT [NUM_PATTERNS] = '{
    112'h796f7574756265,
    112'h676f6f676c65766964656f,
    112'h6e6574666c6978,
    112'h66616365626f6f6b,
    112'h666263646e,
    112'h696e7374616772616d,
    112'h74696b746f6b,
    112'h6d75736963616c6c79,
    112'h74776974746572,
    112'h7477696d67,
    112'h7768617473617070,
    112'h74656c656772616d,
    112'h676974687562,
    112'h726564646974,
    112'h737465616d706f7765726564,
    112'h737465616d636f6d6d756e697479,
    112'h676f6f676c65,
    112'h67737461746963
  };

  localparam int PATTERN_LEN [NUM_PATTERNS] = '{
    7, 11, 7, 8, 5, 9, 6, 9, 7, 5, 8, 8, 6, 6, 12, 14, 6, 7
  };

  localparam class_code_e PATTERN_CLASS [NUM_PATTERNS] = '{
    CLS_VIDEO, CLS_VIDEO, CLS_MOVIES, CLS_SOCIAL, CLS_SOCIAL, CLS_PHOTO,
    CLS_SHORTS, CLS_SHORTS, CLS_MICROBLOG, CLS_MICROBLOG, CLS_CHAT,
    CLS_MESSENGER, CLS_CODE_HOST, CLS_FORUM, CLS_GAMES, CLS_GAMES,
    CLS_SEARCH, CLS_SEARCH
  };

  localparam int NUM_ROWS = 25;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, CLS_NONE},
    '{8'hff, 1'b1, 1'b1, 1'b1, CLS_NONE},
    '{8'h40, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h5b, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h41, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h5a, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h00, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, CLS_NONE},
    '{8'h54, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h77, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h49, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h6d, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h47, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h66, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h42, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h63, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h44, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h6e, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h00, 1'b0, 1'b1, 1'b0, CLS_NONE},
    '{8'h47, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h49, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h54, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h48, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h55, 1'b1, 1'b0, 1'b0, CLS_NONE},
    '{8'h42, 1'b1, 1'b1, 1'b0, CLS_NONE}
  };

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] byte_value_i   = 8'h00;
  logic       byte_present_i = 1'b0;
  logic       last_byte_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [3:0] class_code_o;

  logic [103:0] name_window  = '0;
  logic [11:0]  seen_classes = '0;
  class_code_e  expected_codes [$];
  name_item_t   name_bytes [$];
  int           idle_pct    = 20;
  int           sent_items  = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  hostname_substring_classifier_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .class_code_o   (class_code_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void classify_byte(input name_item_t it, output bit done,
                                        output class_code_e code);
    logic [111:0] win;
    logic [111:0] mask;
    logic [7:0]   folded;
    int           k;
    done = 1'b0;
    code = CLS_NONE;
    if (it.present) begin
      folded = it.value;
      if (folded >= 8'h41 && folded <= 8'h5a) begin
        folded = folded + 8'h20;
      end
      win = {name_window, folded};
      for (k = 0; k < NUM_PATTERNS; k++) begin
        mask = {112{1'b1}} >> (112 - 8 * PATTERN_LEN[k]);
        if ((win & mask) == PATTERN_TEXT[k]) begin
          seen_classes[PATTERN_CLASS[k]] = 1'b1;
        end
      end
      name_window = win[103:0];
    end
    if (it.last) begin
      done = 1'b1;
      for (k = NUM_CLASSES - 1; k >= 0; k--) begin
        if (seen_classes[k]) begin
          code = class_code_e'(k);
        end
      end
      name_window  = '0;
      seen_classes = '0;
    end
  endfunction

  function automatic logic [7:0] filler_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h41 + 8'($urandom_range(0, 25));
      3: return 8'h30 + 8'($urandom_range(0, 9));
      4: return $urandom_range(0, 1) ? 8'h2e : 8'h2d;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] value);
    name_bytes.push_back('{value, 1'b1, 1'b0});
  endfunction

  function automatic void add_gap();
    name_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
  endfunction

  // mostly names with embedded patterns, some empty names and raw noise
  function automatic void make_name();
    int         kind;
    int         pick;
    int         len;
    int         pos;
    logic [7:0] ch;
    name_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      repeat ($urandom_range(0, 5)) add_byte(filler_char());
      repeat ($urandom_range(1, 2)) begin
        pick = $urandom_range(0, NUM_PATTERNS - 1);
        len  = PATTERN_LEN[pick];
        for (pos = 0; pos < len; pos++) begin
          ch = PATTERN_TEXT[pick][8 * (len - 1 - pos) +: 8];
          if ($urandom_range(0, 3) == 0) begin
            ch = ch - 8'h20;
          end
          if ($urandom_range(0, 39) == 0) begin
            ch = filler_char();
          end
          add_byte(ch);
          if ($urandom_range(0, 29) == 0) begin
            add_gap();
          end
        end
        repeat ($urandom_range(0, 3)) add_byte(filler_char());
      end
    end else if (kind < 82) begin
      repeat ($urandom_range(0, 2)) add_gap();
    end else begin
      repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
    end
    if (name_bytes.size() == 0 || $urandom_range(0, 9) == 0) begin
      add_gap();
    end
    name_bytes[name_bytes.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(input name_item_t it, input bit typed,
                           input class_code_e typed_code);
    bit          done;
    class_code_e code;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_value_i   <= it.value;
    byte_present_i <= it.present;
    last_byte_i    <= it.last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    classify_byte(it, done, code);
    if (done) begin
      expected_codes.push_back(typed ? typed_code : code);
    end
    if (it.present || it.last) begin
      sent_items++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  // result check on every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected result, actual class %0d", $time, class_code_o);
        error_count++;
      end else begin
        if (class_code_o !== expected_codes[0]) begin
          $display("%0t: class mismatch, expected %0d, actual %0d", $time,
                   expected_codes[0], class_code_o);
          error_count++;
        end
        void'(expected_codes.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int  row;
    bit  paused;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (row = 0; row < NUM_ROWS; row++) begin
      send_item('{DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].present,
                  DIRECTED_ROWS[row].last}, DIRECTED_ROWS[row].typed,
                DIRECTED_ROWS[row].code);
    end
    wait_drained();
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      idle_pct = (sent_items >= 250 && sent_items < 450) ? 0 : 20;
      if (!paused && sent_items >= 500) begin
        wait_drained();
        paused = 1'b1;
      end
      make_name();
      foreach (name_bytes[i]) begin
        send_item(name_bytes[i], 1'b0, CLS_NONE);
      end
    end
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/hsc_pkg.sv
src/hsc_cell.sv
src/hsc_match.sv
src/hostname_substring_classifier_core.sv
tb/tb_top.sv
